[hw/rtl/zasf_pkg.sv]
// Package of shared constants for the Z-algorithm substring finder.
package zasf_pkg;

   // Field widths fixed by the interface.
   localparam int unsigned SYM_W = 8;
   localparam int unsigned PAT_W = 6;
   localparam int unsigned POS_W = 6;

   // Separator placed between pattern and text.
   localparam logic [SYM_W-1:0] SEP_BYTE = 8'h23;

   // Largest number of results reported for one search.
   localparam logic [POS_W-1:0] RESULT_CAP = 6'd63;

   // Sequencer state codes.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SEP   = 3'd1;
   localparam logic [2:0] ST_ZLOAD = 3'd2;
   localparam logic [2:0] ST_CMP   = 3'd3;
   localparam logic [2:0] ST_FLUSH = 3'd4;

endpackage

[hw/rtl/z_algorithm_substring_finder.sv]
// Z-algorithm substring finder: byte buffer, Z pass sequencer and result output.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-----------------------------------------
//  request  | in        | start, busy           | req_symbol, req_final_byte
//  response | out       | rsp_strobe (1 cycle)  | rsp_match_position, rsp_found,
//           |           |                       | rsp_overflow, rsp_last_result
//  csr      | in        | csr_write_en          | csr_write_data (pattern length)
//
// A request byte is taken in the idle state; the last pattern byte also holds the block in
// the separator state, as the separator goes through the same buffer port. The final byte
// starts the Z pass: a load state per buffer position, then a compare per matching
// character and a closing one, bounded by the single compare unit and the registered
// reads of the two buffers. Each match is held until the next one is found and appears in
// the cycle after that compare; the final response follows the flush state, as busy falls.
// Reset is synchronous and clears the control state; the receiver cannot stall.
module z_algorithm_substring_finder
   import zasf_pkg::*;
#(
   parameter int unsigned MAX_LEN = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [SYM_W-1:0] req_symbol,
   input  logic             req_final_byte,
   input  logic             csr_write_en,
   input  logic [PAT_W-1:0] csr_write_data,
   output logic             rsp_strobe,
   output logic [POS_W-1:0] rsp_match_position,
   output logic             rsp_found,
   output logic             rsp_overflow,
   output logic             rsp_last_result
);

   localparam int unsigned LW = $clog2(MAX_LEN + 1);
   localparam int unsigned AW = $clog2(MAX_LEN);
   localparam int unsigned CW = (LW > PAT_W) ? LW : PAT_W;
   localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LEN);
   localparam logic [LW-1:0] ONE = LW'(1);

   // Pattern length register.
   logic [PAT_W-1:0] plen_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= PAT_W'(1);
      end else if (csr_write_en) begin
         plen_ff <= csr_write_data;
      end
   end

   // Control and payload registers.
   logic [2:0]       state_ff, state_in;
   logic [PAT_W-1:0] pat_ff, pat_in;
   logic [LW-1:0]    fill_ff, fill_in;
   logic             drop_ff, drop_in;
   logic             fin_ff, fin_in;
   logic [LW-1:0]    i_ff, i_in;
   logic [LW-1:0]    l_ff, l_in;
   logic [LW-1:0]    r_ff, r_in;
   logic [LW-1:0]    zi_ff, zi_in;
   logic [POS_W-1:0] cnt_ff, cnt_in;
   logic             pend_ff, pend_in;
   logic [POS_W-1:0] ppos_ff, ppos_in;
   logic             strobe_ff, strobe_in;
   logic [POS_W-1:0] opos_ff, opos_in;
   logic             ofound_ff, ofound_in;
   logic             oovf_ff, oovf_in;
   logic             olast_ff, olast_in;

   // Buffers and their ports.
   logic [SYM_W-1:0] str_mem [MAX_LEN];
   logic [LW-1:0]    z_mem [MAX_LEN];
   logic             s_we;
   logic [AW-1:0]    s_waddr;
   logic [SYM_W-1:0] s_wdata;
   logic [AW-1:0]    s_raddr_a, s_raddr_b;
   logic [SYM_W-1:0] s_rd_a_ff, s_rd_b_ff;
   logic             z_we;
   logic [AW-1:0]    z_waddr, z_raddr;
   logic [LW-1:0]    z_rd_ff;

   // Helper values for the sequencer.
   logic [PAT_W-1:0] p_eff;
   logic [LW-1:0]    fill_new;
   logic [LW-1:0]    lim;
   logic [LW-1:0]    zi0;
   logic [LW-1:0]    sum_iz;
   logic [LW-1:0]    sum_b;
   logic [LW-1:0]    z_rsub;
   logic             extend;
   logic             is_match;
   logic [CW-1:0]    i_ext, zi_ext, p_ext, pos_ext;

   assign p_eff  = (plen_ff == '0) ? PAT_W'(1) : plen_ff;
   assign lim    = r_ff - i_ff;
   assign zi0    = (i_ff < r_ff) ? ((z_rd_ff < lim) ? z_rd_ff : lim) : '0;
   assign sum_iz = i_ff + zi_ff;
   assign extend = (sum_iz < fill_ff) && (s_rd_a_ff == s_rd_b_ff);
   assign i_ext  = CW'(i_ff);
   assign zi_ext = CW'(zi_ff);
   assign p_ext  = CW'(pat_ff);
   assign pos_ext = i_ext - p_ext - CW'(1);
   assign is_match = (i_ext > p_ext) && (zi_ext >= p_ext);

   // Read addresses follow the next values, so data is ready in the following state.
   assign sum_b     = i_ff + zi_in;
   assign s_raddr_a = zi_in[AW-1:0];
   assign s_raddr_b = sum_b[AW-1:0];
   assign z_rsub    = i_in - l_in;
   assign z_raddr   = z_rsub[AW-1:0];

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      pat_in    = pat_ff;
      fill_in   = fill_ff;
      drop_in   = drop_ff;
      fin_in    = fin_ff;
      i_in      = i_ff;
      l_in      = l_ff;
      r_in      = r_ff;
      zi_in     = zi_ff;
      cnt_in    = cnt_ff;
      pend_in   = pend_ff;
      ppos_in   = ppos_ff;
      strobe_in = 1'b0;
      opos_in   = opos_ff;
      ofound_in = ofound_ff;
      oovf_in   = oovf_ff;
      olast_in  = olast_ff;
      s_we      = 1'b0;
      s_waddr   = fill_ff[AW-1:0];
      s_wdata   = req_symbol;
      z_we      = 1'b0;
      z_waddr   = i_ff[AW-1:0];
      fill_new  = fill_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               pat_in = p_eff;
               // Store the byte, or note that it was dropped.
               if (fill_ff < LEN_MAX) begin
                  s_we     = 1'b1;
                  fill_new = fill_ff + ONE;
               end else begin
                  drop_in = 1'b1;
               end
               fill_in = fill_new;
               fin_in  = req_final_byte;
               if ((CW'(fill_new) == CW'(p_eff)) && (fill_new < LEN_MAX)) begin
                  state_in = ST_SEP;
               end else begin
                  if (CW'(fill_new) == CW'(p_eff)) begin
                     drop_in = 1'b1;
                  end
                  if (req_final_byte) begin
                     i_in = ONE;
                     l_in = '0;
                     r_in = '0;
                     state_in = (fill_new > ONE) ? ST_ZLOAD : ST_FLUSH;
                  end
               end
            end
         end
         ST_SEP: begin
            // Separator after the pattern's last byte.
            s_we    = 1'b1;
            s_wdata = SEP_BYTE;
            fill_in = fill_ff + ONE;
            if (fin_ff) begin
               i_in = ONE;
               l_in = '0;
               r_in = '0;
               state_in = ST_ZLOAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ZLOAD: begin
            // Starting length from the window, or zero outside it.
            zi_in    = zi0;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (extend) begin
               zi_in = zi_ff + ONE;
            end else begin
               z_we = 1'b1;
               if (sum_iz > r_ff) begin
                  l_in = i_ff;
                  r_in = sum_iz;
               end
               i_in = i_ff + ONE;
               if (is_match) begin
                  // Hold the newest match back until we know whether it is the last.
                  if (pend_ff) begin
                     strobe_in = 1'b1;
                     opos_in   = ppos_ff;
                     ofound_in = 1'b1;
                     oovf_in   = drop_ff;
                     olast_in  = 1'b0;
                  end
                  pend_in = 1'b1;
                  ppos_in = pos_ext[POS_W-1:0];
                  cnt_in  = cnt_ff + POS_W'(1);
               end
               if ((is_match && (cnt_ff + POS_W'(1) == RESULT_CAP)) ||
                   (i_ff + ONE == fill_ff)) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_ZLOAD;
               end
            end
         end
         ST_FLUSH: begin
            // Final response: the pending match, or the no-match result.
            strobe_in = 1'b1;
            opos_in   = pend_ff ? ppos_ff : '0;
            ofound_in = pend_ff;
            oovf_in   = drop_ff;
            olast_in  = 1'b1;
            fill_in   = '0;
            drop_in   = 1'b0;
            cnt_in    = '0;
            pend_in   = 1'b0;
            l_in      = '0;
            r_in      = '0;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         drop_ff   <= 1'b0;
         fin_ff    <= 1'b0;
         l_ff      <= '0;
         r_ff      <= '0;
         cnt_ff    <= '0;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         drop_ff   <= drop_in;
         fin_ff    <= fin_in;
         l_ff      <= l_in;
         r_ff      <= r_in;
         cnt_ff    <= cnt_in;
         pend_ff   <= pend_in;
         strobe_ff <= strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pat_ff    <= pat_in;
      i_ff      <= i_in;
      zi_ff     <= zi_in;
      ppos_ff   <= ppos_in;
      opos_ff   <= opos_in;
      ofound_ff <= ofound_in;
      oovf_ff   <= oovf_in;
      olast_ff  <= olast_in;
   end

   // String buffer: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (s_we) begin
         str_mem[s_waddr] <= s_wdata;
      end
      s_rd_a_ff <= str_mem[s_raddr_a];
      s_rd_b_ff <= str_mem[s_raddr_b];
   end

   // Z buffer: a read of the entry being written returns the new value.
   always_ff @(posedge clock) begin
      if (z_we) begin
         z_mem[z_waddr] <= zi_ff;
      end
      if (z_we && (z_waddr == z_raddr)) begin
         z_rd_ff <= zi_ff;
      end else begin
         z_rd_ff <= z_mem[z_raddr];
      end
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_strobe         = strobe_ff;
   assign rsp_match_position = opos_ff;
   assign rsp_found          = ofound_ff;
   assign rsp_overflow       = oovf_ff;
   assign rsp_last_result    = olast_ff;

   // A no-match response is always the final one.
   a_nomatch_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_found) |-> rsp_last_result)
      else $error("no-match response without last flag");

   // The block is idle when the final response appears.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_result) |-> (state_ff == ST_IDLE))
      else $error("final response while search still running");

   // The compare never runs past the filled part of the buffer.
   a_cmp_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> ((i_ff + zi_ff) <= fill_ff))
      else $error("compare beyond buffer fill");

   // The fill count stays within capacity.
   a_fill_cap: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LEN_MAX)
      else $error("fill count beyond capacity");

endmodule

[tb/sv/zasf_checker.sv]
`timescale 1ns / 100ps
// Checker that tracks the substring finder's requests, predicts its search results and compares them.
module zasf_checker
   import zasf_pkg::*;
#(
   parameter int unsigned MAX_LEN = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  logic [SYM_W-1:0] req_symbol,
   input  logic             req_final_byte,
   input  logic             csr_write_en,
   input  logic [PAT_W-1:0] csr_write_data,
   input  logic             rsp_strobe,
   input  logic [POS_W-1:0] rsp_match_position,
   input  logic             rsp_found,
   input  logic             rsp_overflow,
   input  logic             rsp_last_result,
   output int unsigned      fail_count,
   output int unsigned      pending_count
);

   // One predicted search result.
   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             found;
      logic             overflow;
      logic             last;
   } hit_type;

   hit_type          pending_hits[$];
   logic [PAT_W-1:0] pat_len_reg;
   logic [SYM_W-1:0] buffer[MAX_LEN];
   int unsigned      zval[MAX_LEN];
   int unsigned      fill;
   logic             dropped;

   initial begin
      fail_count = 0;
      pending_count = 0;
      pat_len_reg = PAT_W'(1);
      fill = 0;
      dropped = 1'b0;
   end

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   // Adds one byte to the buffer; on the final byte runs the Z pass and queues the hits.
   task automatic scan_symbol(input logic [SYM_W-1:0] sym, input logic fin);
      int unsigned plen;
      int unsigned n;
      int unsigned lo;
      int unsigned hi;
      int unsigned zi;
      int unsigned k;
      int unsigned i;
      int unsigned count;
      hit_type     h;
      plen = (pat_len_reg == '0) ? 1 : int'(pat_len_reg);

      // Bytes beyond the buffer are dropped and flagged.
      if (fill < MAX_LEN) begin
         buffer[fill] = sym;
         fill++;
      end else begin
         dropped = 1'b1;
      end

      // The last pattern byte also places the separator.
      if (fill == plen) begin
         if (fill < MAX_LEN) begin
            buffer[fill] = SEP_BYTE;
            fill++;
         end else begin
            dropped = 1'b1;
         end
      end
      if (!fin)
         return;

      // Z array over pattern, separator and text, with the usual l/r window.
      n = fill;
      lo = 0;
      hi = 0;
      if (n != 0)
         zval[0] = n;
      for (i = 1; i < n; i++) begin
         zi = 0;
         if (i < hi) begin
            k = zval[i - lo];
            zi = (k < hi - i) ? k : hi - i;
         end
         while (i + zi < n && buffer[zi] == buffer[i + zi])
            zi++;
         if (i + zi > hi) begin
            lo = i;
            hi = i + zi;
         end
         zval[i] = zi;
      end

      // Every text position whose Z value covers the pattern is an occurrence.
      count = 0;
      for (i = plen + 1; i < n && count < RESULT_CAP; i++) begin
         if (zval[i] >= plen) begin
            h.position = POS_W'(i - plen - 1);
            h.found = 1'b1;
            h.overflow = dropped;
            h.last = 1'b0;
            pending_hits = {pending_hits, h};
            count++;
         end
      end
      if (count == 0) begin
         h.position = '0;
         h.found = 1'b0;
         h.overflow = dropped;
         h.last = 1'b1;
         pending_hits = {pending_hits, h};
      end else begin
         h = pending_hits.pop_back();
         h.last = 1'b1;
         pending_hits = {pending_hits, h};
      end

      // The stream starts over after a search.
      fill = 0;
      dropped = 1'b0;
   endtask

   // Sample both channels and the register port at each rising edge.
   always @(posedge clock) begin
      hit_type want;
      if (reset) begin
         pat_len_reg = PAT_W'(1);
         fill = 0;
         dropped = 1'b0;
         pending_hits.delete();
      end else begin
         if (rsp_strobe) begin
            if (pending_hits.size() == 0) begin
               report_mismatch("result with none pending, position", rsp_match_position, 0);
            end else begin
               want = pending_hits.pop_front();
               if (rsp_match_position !== want.position)
                  report_mismatch("match_position", rsp_match_position, want.position);
               if (rsp_found !== want.found)
                  report_mismatch("found", rsp_found, want.found);
               if (rsp_overflow !== want.overflow)
                  report_mismatch("overflow", rsp_overflow, want.overflow);
               if (rsp_last_result !== want.last)
                  report_mismatch("last_result", rsp_last_result, want.last);
            end
         end
         if (csr_write_en)
            pat_len_reg = csr_write_data;
         if (start && !busy)
            scan_symbol(req_symbol, req_final_byte);
      end
      pending_count = pending_hits.size();
   end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Top of the substring finder testbench: clock, reset, request stimulus and the verdict.
module tb_top
   import zasf_pkg::*;
;

   localparam int unsigned MAX_LEN       = 64;
   localparam int unsigned ITEM_TARGET   = 400;
   localparam int unsigned QUIET_TAIL    = 60;
   localparam int unsigned SETTLE_CYCLES = 300;
   localparam int unsigned CSR_GUARD     = 4;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic [SYM_W-1:0] req_symbol;
   logic             req_final_byte;
   logic             csr_write_en;
   logic [PAT_W-1:0] csr_write_data;
   logic             rsp_strobe;
   logic [POS_W-1:0] rsp_match_position;
   logic             rsp_found;
   logic             rsp_overflow;
   logic             rsp_last_result;
   int unsigned      fail_count;
   int unsigned      pending_count;

   int unsigned      items_sent;
   int unsigned      cur_len;
   logic             gaps_on;

   z_algorithm_substring_finder #(.MAX_LEN(MAX_LEN)) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_symbol         (req_symbol),
      .req_final_byte     (req_final_byte),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data),
      .rsp_strobe         (rsp_strobe),
      .rsp_match_position (rsp_match_position),
      .rsp_found          (rsp_found),
      .rsp_overflow       (rsp_overflow),
      .rsp_last_result    (rsp_last_result)
   );

   zasf_checker #(.MAX_LEN(MAX_LEN)) scoreboard (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_symbol         (req_symbol),
      .req_final_byte     (req_final_byte),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data),
      .rsp_strobe         (rsp_strobe),
      .rsp_match_position (rsp_match_position),
      .rsp_found          (rsp_found),
      .rsp_overflow       (rsp_overflow),
      .rsp_last_result    (rsp_last_result),
      .fail_count         (fail_count),
      .pending_count      (pending_count)
   );

   // 10 ns clock.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Now and then the sender pauses for a burst of idle cycles.
   task automatic maybe_gap();
      int unsigned len;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         len = $urandom_range(1, 17);
         @(negedge clock);
         start <= 1'b0;
         repeat (len - 1) @(negedge clock);
      end
   endtask

   // Presents one request and waits until the block takes it.
   task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic fin);
      maybe_gap();
      @(negedge clock);
      start <= 1'b1;
      req_symbol <= sym;
      req_final_byte <= fin;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      items_sent++;
   endtask

   // Writes the pattern length once the block has settled and nothing is pending.
   task automatic write_length(input logic [PAT_W-1:0] len);
      @(negedge clock);
      start <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (CSR_GUARD) @(negedge clock);
      while (busy)
         @(negedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= len;
      @(negedge clock);
      csr_write_en <= 1'b0;
      cur_len = (len == '0) ? 1 : int'(len);
   endtask

   // Builds one search at random: mostly a pattern with copies of it in the text,
   // sometimes noise, an overfull buffer, a final byte inside the pattern, or a
   // change of pattern length part way through.
   task automatic run_random_search();
      logic [SYM_W-1:0] stream[$];
      logic [SYM_W-1:0] pat[$];
      logic [SYM_W-1:0] alpha[2];
      int unsigned      kind;
      int unsigned      text_len;
      int unsigned      cut;
      int unsigned      midpoint;
      int unsigned      i;
      logic             narrow;
      kind = $urandom_range(0, 99);
      narrow = ($urandom_range(0, 3) != 0);
      alpha[0] = SYM_W'($urandom);
      alpha[1] = SYM_W'($urandom);
      midpoint = 0;

      for (i = 0; i < cur_len; i++)
         pat = {pat, (narrow ? alpha[$urandom_range(0, 1)] : SYM_W'($urandom))};
      stream = pat;

      // Text length: short by default, past the buffer for the overflow shape.
      if (kind < 15)
         text_len = MAX_LEN - cur_len - 1 + $urandom_range(1, 8);
      else
         text_len = $urandom_range(0, 14);

      while (stream.size() < cur_len + text_len) begin
         if (narrow && $urandom_range(0, 2) == 0)
            stream = {stream, pat};
         else
            stream = {stream, (narrow ? alpha[$urandom_range(0, 1)] : SYM_W'($urandom))};
      end

      // Broken stream: the final byte comes before the pattern is complete.
      if (kind >= 95) begin
         cut = $urandom_range(1, cur_len);
         while (stream.size() > cut)
            void'(stream.pop_back());
      end

      // Pattern length rewritten part way through the stream.
      if (kind >= 88 && kind < 95 && stream.size() >= 2)
         midpoint = $urandom_range(1, stream.size() - 1);

      for (i = 0; i < stream.size(); i++) begin
         if (midpoint != 0 && i == midpoint)
            write_length(PAT_W'($urandom_range(0, 8)));
         send_symbol(stream[i], i == stream.size() - 1);
      end
   endtask

   // Stimulus: directed searches, then random phases at several pattern lengths.
   initial begin
      int unsigned      phase;
      int unsigned      phase_start;
      logic [PAT_W-1:0] len_plan[10];
      logic [PAT_W-1:0] next_len;
      len_plan = '{6'd1, 6'd62, 6'd4, 6'd0, 6'd63, 6'd2, 6'd3, 6'd6, 6'd1, 6'd5};
      reset = 1'b1;
      start = 1'b0;
      req_symbol = '0;
      req_final_byte = 1'b0;
      csr_write_en = 1'b0;
      csr_write_data = '0;
      items_sent = 0;
      cur_len = 1;
      gaps_on = 1'b1;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Final byte on the only pattern byte: empty text, one no-match result.
      send_symbol(8'h41, 1'b1);
      // All-zero and all-one bytes, two occurrences.
      send_symbol(8'h00, 1'b0);
      send_symbol(8'h00, 1'b0);
      send_symbol(8'hFF, 1'b0);
      send_symbol(8'h00, 1'b1);
      // Final byte while the pattern is still arriving.
      write_length(6'd3);
      send_symbol(8'h78, 1'b0);
      send_symbol(8'h79, 1'b1);
      // Separator byte inside the pattern.
      write_length(6'd2);
      repeat (4) send_symbol(SEP_BYTE, 1'b0);
      send_symbol(SEP_BYTE, 1'b1);
      // Zero pattern length behaves as one.
      write_length(6'd0);
      send_symbol(8'hFF, 1'b0);
      send_symbol(8'hFF, 1'b0);
      send_symbol(8'h5A, 1'b1);
      // Pattern length changed while the stream is under way.
      write_length(6'd2);
      send_symbol(8'h61, 1'b0);
      send_symbol(8'h62, 1'b0);
      write_length(6'd1);
      send_symbol(8'h61, 1'b0);
      send_symbol(8'h62, 1'b1);

      // Random phases; long patterns get a single search each.
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         next_len = (phase < 10) ? len_plan[phase] : PAT_W'($urandom_range(1, 8));
         write_length(next_len);
         phase_start = items_sent;
         do begin
            if (items_sent >= ITEM_TARGET - QUIET_TAIL)
               gaps_on = 1'b0;
            run_random_search();
         end while (cur_len < 32 && items_sent - phase_start < 40);
         phase++;
      end

      // Drain the results, then allow the block's latency before the verdict.
      @(negedge clock);
      start <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin
      #5000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
